// ===== sv/rc_pulse_capture_validator_assert.svh =====
// ----------------------------------------------------------------------------
// RC pulse capture validator: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RC_PULSE_CAPTURE_VALIDATOR_ASSERT_SVH
`define RC_PULSE_CAPTURE_VALIDATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCPV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCPV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`define RCPV_ASSERT_TWO(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

// ===== sv/rcpv_pkg.sv =====
// ----------------------------------------------------------------------------
// RC pulse capture validator package
// Widths, register codes, reset values, shared types and helper functions.
// ----------------------------------------------------------------------------
package rcpv_pkg;

    // Field widths fixed by the interface.
    localparam int CHANNELS_DEF = 6;
    localparam int CHAN_W       = 3;
    localparam int TIME_W       = 32;
    localparam int PULSE_W      = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // Register reset values.
    localparam logic [PULSE_W-1:0] MIN_PULSE_RST    = 16'd800;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST    = 16'd2200;
    localparam logic [PULSE_W-1:0] EDGE_LOCKOUT_RST = 16'd100;
    localparam logic [PULSE_W-1:0] SMALL_STEP_RST   = 16'd60;
    localparam logic [PULSE_W-1:0] MEDIUM_STEP_RST  = 16'd200;
    localparam logic [PULSE_W-1:0] MEDIUM_MATCH_RST = 16'd80;
    localparam logic [PULSE_W-1:0] LARGE_MATCH_RST  = 16'd100;

    // Number of consistent large steps before a large step is taken.
    localparam logic [1:0] LARGE_CONFIRM = 2'd2;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_RISE    = 3'd1,
        ST_RANGE   = 3'd2,
        ST_ACCEPT  = 3'd3,
        ST_HELD    = 3'd4
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PULSE    = 3'd0,
        REG_MAX_PULSE    = 3'd1,
        REG_EDGE_LOCKOUT = 3'd2,
        REG_SMALL_STEP   = 3'd3,
        REG_MEDIUM_STEP  = 3'd4,
        REG_MEDIUM_MATCH = 3'd5,
        REG_LARGE_MATCH  = 3'd6
    } cfg_reg_t;

    // Configuration register bank as seen by the datapath.
    typedef struct packed {
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] max_pulse;
        logic [PULSE_W-1:0] edge_lockout;
        logic [PULSE_W-1:0] small_step;
        logic [PULSE_W-1:0] medium_step;
        logic [PULSE_W-1:0] medium_match;
        logic [PULSE_W-1:0] large_match;
    } cfg_t;

    // Per-channel filter state.
    typedef struct packed {
        logic [PULSE_W-1:0] held;
        logic [PULSE_W-1:0] cand;
        logic               pending;
        logic [1:0]         large_count;
        logic [PULSE_W-1:0] last_large;
    } filt_state_t;

    // Complete per-channel entry.
    typedef struct packed {
        filt_state_t       filt;
        logic [TIME_W-1:0] accept_time;
        logic [TIME_W-1:0] edge_time;
        logic [TIME_W-1:0] rise_time;
    } chan_entry_t;

    // Absolute difference of two pulse widths.
    function automatic logic [PULSE_W-1:0] abs_diff(input logic [PULSE_W-1:0] a,
                                                    input logic [PULSE_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== sv/rcpv_if.sv =====
// ----------------------------------------------------------------------------
// RC pulse capture validator channel interfaces
// Edge event, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------

// Edge events into the block.
interface rcpv_evt_if import rcpv_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] chan;
    logic              level;
    logic [TIME_W-1:0] time_us;

    modport source (output valid, chan, level, time_us, input ready);
    modport sink   (input valid, chan, level, time_us, output ready);
endinterface

// Results out of the block.
interface rcpv_res_if import rcpv_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CHAN_W-1:0]  chan_out;
    status_t            status;
    logic [PULSE_W-1:0] pulse_us;
    logic [TIME_W-1:0]  valid_time_us;

    modport source (output valid, chan_out, status, pulse_us, valid_time_us, input ready);
    modport sink   (input valid, chan_out, status, pulse_us, valid_time_us, output ready);
endinterface

// Configuration register writes.
interface rcpv_cfg_if import rcpv_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/rc_pulse_capture_validator.sv =====
// ----------------------------------------------------------------------------
// RC pulse capture validator
// Per-channel pulse width capture from pin edges, with lockout, range limits
// and a step filter on the held width.
//
//  Channel  Role    Payload
//  evt      sink    chan, level, time_us
//  res      source  chan_out, status, pulse_us, valid_time_us
//  cfg      sink    index, data (register write)
//
// An event passes an input register and one stage of logic that reads and
// updates the channel's state. Its result is registered in the result register
// when that stage fires, which a stalled result can hold off. One event is taken
// every cycle while results are not stalled, set by the single state update.
// Reset clears every channel's state and loads the register defaults.
// A stalled result holds the stage behind it; an empty input register still
// takes one more event.
// ----------------------------------------------------------------------------
module rc_pulse_capture_validator import rcpv_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    rcpv_evt_if.sink  evt,
    rcpv_res_if.source res,
    rcpv_cfg_if.sink  cfg
);

    localparam int              IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int              EXT_W    = 5;
    localparam logic [EXT_W-1:0] CH_LIMIT = EXT_W'(CHANNELS);

    cfg_t cfg_vals;

    // Input register.
    logic              s1_valid_reg, s1_valid_next;
    logic [CHAN_W-1:0] s1_chan_reg;
    logic              s1_level_reg;
    logic [TIME_W-1:0] s1_time_reg;

    // Result register.
    logic               out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]  out_chan_reg;
    status_t            out_status_reg;
    logic [PULSE_W-1:0] out_pulse_reg;
    logic [TIME_W-1:0]  out_vtime_reg;

    logic               advance;
    logic               take_in;
    logic               fire;
    logic [EXT_W-1:0]   chan_ext;
    logic               chan_ok;
    logic [IDX_W-1:0]   idx;
    chan_entry_t        cur_entry;
    chan_entry_t        nxt_entry;
    status_t            step_status;

    // Configuration registers.
    rcpv_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_vals (cfg_vals)
    );

    // Flow control between the two registers.
    assign advance   = !out_valid_reg || res.ready;
    assign evt.ready = !s1_valid_reg || advance;
    assign take_in   = evt.valid && evt.ready;
    assign fire      = s1_valid_reg && advance;

    // Channel range check and state index.
    assign chan_ext = {{(EXT_W-CHAN_W){1'b0}}, s1_chan_reg};
    assign chan_ok  = chan_ext < CH_LIMIT;
    assign idx      = chan_ext[IDX_W-1:0];

    // Per-channel state.
    rcpv_chan_store #(.CHANNELS(CHANNELS), .IDX_W(IDX_W)) u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .idx     (idx),
        .wr_en   (fire && chan_ok),
        .wr_data (nxt_entry),
        .rd_data (cur_entry)
    );

    // Edge processing.
    rcpv_step u_step
    (
        .cfg_vals (cfg_vals),
        .cur      (cur_entry),
        .level    (s1_level_reg),
        .now      (s1_time_reg),
        .nxt      (nxt_entry),
        .status   (step_status)
    );

    // Valid flags of both registers.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take_in)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input payload capture.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_chan_reg  <= evt.chan;
            s1_level_reg <= evt.level;
            s1_time_reg  <= evt.time_us;
        end
    end

    // Result payload capture; an unknown channel reports zeros.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_chan_reg   <= s1_chan_reg;
            out_status_reg <= chan_ok ? step_status : ST_IGNORED;
            out_pulse_reg  <= chan_ok ? nxt_entry.filt.held : '0;
            out_vtime_reg  <= chan_ok ? nxt_entry.accept_time : '0;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.chan_out      = out_chan_reg;
    assign res.status        = out_status_reg;
    assign res.pulse_us      = out_pulse_reg;
    assign res.valid_time_us = out_vtime_reg;

endmodule

// ===== sv/rcpv_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// RC pulse capture validator configuration registers
// Holds the seven limit and threshold registers, written one per transfer.
// ----------------------------------------------------------------------------
module rcpv_cfg_regs import rcpv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rcpv_cfg_if.sink   cfg,
    output cfg_t       cfg_vals
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign cfg.ready = 1'b1;
    assign cfg_vals  = cfg_reg;

    // Decode the register index of a write transfer; unused indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_MIN_PULSE:    cfg_next.min_pulse    = cfg.data;
                REG_MAX_PULSE:    cfg_next.max_pulse    = cfg.data;
                REG_EDGE_LOCKOUT: cfg_next.edge_lockout = cfg.data;
                REG_SMALL_STEP:   cfg_next.small_step   = cfg.data;
                REG_MEDIUM_STEP:  cfg_next.medium_step  = cfg.data;
                REG_MEDIUM_MATCH: cfg_next.medium_match = cfg.data;
                REG_LARGE_MATCH:  cfg_next.large_match  = cfg.data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // Register bank.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_pulse    <= MIN_PULSE_RST;
            cfg_reg.max_pulse    <= MAX_PULSE_RST;
            cfg_reg.edge_lockout <= EDGE_LOCKOUT_RST;
            cfg_reg.small_step   <= SMALL_STEP_RST;
            cfg_reg.medium_step  <= MEDIUM_STEP_RST;
            cfg_reg.medium_match <= MEDIUM_MATCH_RST;
            cfg_reg.large_match  <= LARGE_MATCH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/rcpv_chan_store.sv =====
// ----------------------------------------------------------------------------
// RC pulse capture validator channel state store
// One flip-flop entry per channel, read and written at the channel index.
// ----------------------------------------------------------------------------
module rcpv_chan_store import rcpv_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] idx,
    input  logic             wr_en,
    input  chan_entry_t      wr_data,
    output chan_entry_t      rd_data
);

    chan_entry_t entry_reg [CHANNELS];

    // Entry of the channel being processed.
    assign rd_data = entry_reg[idx];

    // Every entry clears to zero in reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            entry_reg[idx] <= wr_data;
        end
    end

endmodule

// ===== sv/rcpv_step.sv =====
// ----------------------------------------------------------------------------
// RC pulse capture validator edge step
// Lockout test, width measurement, range check and step filter for one edge.
// ----------------------------------------------------------------------------
module rcpv_step import rcpv_pkg::*;
(
    input  cfg_t              cfg_vals,
    input  chan_entry_t       cur,
    input  logic              level,
    input  logic [TIME_W-1:0] now,
    output chan_entry_t       nxt,
    output status_t           status
);

    logic [TIME_W-1:0]  since_edge;
    logic [TIME_W-1:0]  width;
    logic               lockout_ok;
    logic               range_ok;
    logic [PULSE_W-1:0] w;
    logic [PULSE_W-1:0] step;
    logic               cand_match;
    logic               large_match;
    logic [1:0]         large_inc;

    // Timing and range arithmetic, all modulo 2^32.
    assign since_edge = now - cur.edge_time;
    assign width      = now - cur.rise_time;
    assign lockout_ok = since_edge >= {{(TIME_W-PULSE_W){1'b0}}, cfg_vals.edge_lockout};
    assign range_ok   = (width >= {{(TIME_W-PULSE_W){1'b0}}, cfg_vals.min_pulse})
                     && (width <= {{(TIME_W-PULSE_W){1'b0}}, cfg_vals.max_pulse});
    assign w          = width[PULSE_W-1:0];

    // Distances used by the step filter.
    assign step        = abs_diff(w, cur.filt.held);
    assign cand_match  = cur.filt.pending && (abs_diff(w, cur.filt.cand) < cfg_vals.medium_match);
    assign large_match = abs_diff(w, cur.filt.last_large) < cfg_vals.large_match;
    assign large_inc   = cur.filt.large_count + 2'd1;

    // Next entry and status for the edge.
    always_comb
    begin
        nxt    = cur;
        status = ST_IGNORED;
        if (lockout_ok)
        begin
            nxt.edge_time = now;
            if (level)
            begin
                nxt.rise_time = now;
                status        = ST_RISE;
            end
            else if (!range_ok)
            begin
                status = ST_RANGE;
            end
            else if (step <= cfg_vals.small_step)
            begin
                // Small step: taken at once.
                nxt.filt.held    = w;
                nxt.accept_time  = now;
                nxt.filt.pending = 1'b0;
                status           = ST_ACCEPT;
            end
            else if (step <= cfg_vals.medium_step)
            begin
                // Medium step: taken when it confirms the pending candidate.
                if (cand_match)
                begin
                    nxt.filt.held    = w;
                    nxt.accept_time  = now;
                    nxt.filt.pending = 1'b0;
                    status           = ST_ACCEPT;
                end
                else
                begin
                    nxt.filt.cand    = w;
                    nxt.filt.pending = 1'b1;
                    status           = ST_HELD;
                end
            end
            else
            begin
                // Large step: taken after enough consecutive consistent frames.
                status = ST_HELD;
                if (large_match)
                begin
                    if (large_inc >= LARGE_CONFIRM)
                    begin
                        nxt.filt.held        = w;
                        nxt.accept_time      = now;
                        nxt.filt.large_count = 2'd0;
                        status               = ST_ACCEPT;
                    end
                    else
                    begin
                        nxt.filt.large_count = large_inc;
                    end
                end
                else
                begin
                    nxt.filt.large_count = 2'd0;
                end
                nxt.filt.last_large = w;
                nxt.filt.pending    = 1'b0;
            end
        end
    end

endmodule

// ===== sv/rcpv_checker.sv =====
// ----------------------------------------------------------------------------
// RC pulse capture validator port checker
// Watches the top-level ports for flow and result rules, bound to the top.
// ----------------------------------------------------------------------------
`include "rc_pulse_capture_validator_assert.svh"

module rcpv_checker import rcpv_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               evt_valid,
    input logic               evt_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic [CHAN_W-1:0]  res_chan_out,
    input status_t            res_status,
    input logic [PULSE_W-1:0] res_pulse_us,
    input logic [TIME_W-1:0]  res_valid_time_us,
    input logic               cfg_valid,
    input logic               cfg_ready
);

    localparam int               EXT_W    = 5;
    localparam logic [EXT_W-1:0] CH_LIMIT = EXT_W'(CHANNELS);

    logic chan_bad;
    logic res_stall;
    logic evt_xfer;
    logic bad_zero;

    always_comb
    begin
        chan_bad  = {{(EXT_W-CHAN_W){1'b0}}, res_chan_out} >= CH_LIMIT;
        res_stall = res_valid && !res_ready;
        evt_xfer  = evt_valid && evt_ready;
        bad_zero  = (res_status == ST_IGNORED) && (res_pulse_us == '0)
                 && (res_valid_time_us == '0);
    end

    // A stalled result stays and keeps its payload.
    `RCPV_ASSERT_NEXT(a_res_hold, res_stall, res_valid && $stable(res_chan_out) && $stable(res_status) && $stable(res_pulse_us) && $stable(res_valid_time_us), "stalled result changed")

    // A draining output never blocks the input side.
    `RCPV_ASSERT_SAME(a_evt_flow, res_ready, evt_ready, "input blocked while output drains")

    // Every transferred event is followed by a valid result, which may be an older stalled one.
    `RCPV_ASSERT_TWO(a_evt_latency, evt_xfer, res_valid, "no result two cycles after event")

    // An unknown channel reports an ignored edge with zero fields.
    `RCPV_ASSERT_SAME(a_bad_chan, res_valid && chan_bad, bad_zero, "unknown channel result not cleared")

    // Configuration writes are never held off.
    `RCPV_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind rc_pulse_capture_validator rcpv_checker #(.CHANNELS(CHANNELS)) u_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .evt_valid         (evt.valid),
    .evt_ready         (evt.ready),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_chan_out      (res.chan_out),
    .res_status        (res.status),
    .res_pulse_us      (res.pulse_us),
    .res_valid_time_us (res.valid_time_us),
    .cfg_valid         (cfg.valid),
    .cfg_ready         (cfg.ready)
);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// RC pulse capture validator testbench
// Drives pin-edge events through the block and checks every result against a
// predictor that keeps its own copy of the per-channel capture and step-filter
// state. A directed section covers lockout, wrap, range and filter corner
// cases, then random frame traffic runs under several register settings
// while the sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
    import rcpv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH      = CHANNELS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    // Expected content of one result transfer.
    typedef struct {
        logic [CHAN_W-1:0]  chan;
        status_t            status;
        logic [PULSE_W-1:0] pulse;
        logic [TIME_W-1:0]  stamp;
    } pulse_report_t;

    logic clk;
    logic rst_n;

    rcpv_evt_if evt ();
    rcpv_res_if res ();
    rcpv_cfg_if cfg ();

    rc_pulse_capture_validator #(
        .CHANNELS (NUM_CH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .res   (res),
        .cfg   (cfg)
    );

    // Predictor state: register bank and per-channel capture and filter state.
    cfg_t               lim;
    logic [PULSE_W-1:0] held_w     [NUM_CH];
    logic [TIME_W-1:0]  taken_at   [NUM_CH];
    logic [PULSE_W-1:0] cand_w     [NUM_CH];
    logic               cand_live  [NUM_CH];
    logic [1:0]         big_count  [NUM_CH];
    logic [PULSE_W-1:0] big_last   [NUM_CH];
    logic [TIME_W-1:0]  last_edge  [NUM_CH];
    logic [TIME_W-1:0]  rise_at    [NUM_CH];

    pulse_report_t awaited_reports [$];

    // Stimulus bookkeeping.
    logic [TIME_W-1:0] chan_clock [NUM_CH];
    logic [TIME_W-1:0] last_width [NUM_CH];
    int burst_left;
    int mismatches;
    int events_taken;
    int settings_used;
    int status_seen [5];

    // ------------------------------------------------------------------------
    // Clock, reset and time-zero values on every input.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n       = 1'b0;
        evt.valid   = 1'b0;
        evt.chan    = '0;
        evt.level   = 1'b0;
        evt.time_us = '0;
        cfg.valid   = 1'b0;
        cfg.index   = REG_MIN_PULSE;
        cfg.data    = '0;
        res.ready   = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------------
    function automatic logic [PULSE_W-1:0] width_gap(input logic [PULSE_W-1:0] a,
                                                     input logic [PULSE_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    task automatic clear_predictor();
        lim.min_pulse    = MIN_PULSE_RST;
        lim.max_pulse    = MAX_PULSE_RST;
        lim.edge_lockout = EDGE_LOCKOUT_RST;
        lim.small_step   = SMALL_STEP_RST;
        lim.medium_step  = MEDIUM_STEP_RST;
        lim.medium_match = MEDIUM_MATCH_RST;
        lim.large_match  = LARGE_MATCH_RST;
        for (int c = 0; c < NUM_CH; c++)
        begin
            held_w[c]    = '0;
            taken_at[c]  = '0;
            cand_w[c]    = '0;
            cand_live[c] = 1'b0;
            big_count[c] = '0;
            big_last[c]  = '0;
            last_edge[c] = '0;
            rise_at[c]   = '0;
        end
    endtask

    // Step filter on an in-range width: small steps are taken at once, medium
    // steps need a confirming frame, large steps two more consistent frames.
    function automatic status_t filter_step(input int c, input logic [PULSE_W-1:0] w,
                                            input logic [TIME_W-1:0] now);
        logic [PULSE_W-1:0] step;
        status_t            st;
        step = width_gap(w, held_w[c]);
        if (step <= lim.small_step)
        begin
            held_w[c]    = w;
            taken_at[c]  = now;
            cand_live[c] = 1'b0;
            return ST_ACCEPT;
        end
        if (step <= lim.medium_step)
        begin
            if (cand_live[c] && width_gap(w, cand_w[c]) < lim.medium_match)
            begin
                held_w[c]    = w;
                taken_at[c]  = now;
                cand_live[c] = 1'b0;
                return ST_ACCEPT;
            end
            cand_w[c]    = w;
            cand_live[c] = 1'b1;
            return ST_HELD;
        end
        st = ST_HELD;
        if (width_gap(w, big_last[c]) < lim.large_match)
        begin
            big_count[c] = big_count[c] + 2'd1;
            if (big_count[c] >= LARGE_CONFIRM)
            begin
                held_w[c]    = w;
                taken_at[c]  = now;
                big_count[c] = '0;
                st           = ST_ACCEPT;
            end
        end
        else
        begin
            big_count[c] = '0;
        end
        big_last[c]  = w;
        cand_live[c] = 1'b0;
        return st;
    endfunction

    // Works out the result of one edge event and updates the channel state.
    function automatic pulse_report_t evaluate_edge(input logic [CHAN_W-1:0] ch,
                                                    input logic lvl,
                                                    input logic [TIME_W-1:0] now);
        pulse_report_t     r;
        logic [TIME_W-1:0] since_edge;
        logic [TIME_W-1:0] width;
        int                c;
        r.chan = ch;
        if (ch >= NUM_CH)
        begin
            r.status = ST_IGNORED;
            r.pulse  = '0;
            r.stamp  = '0;
            return r;
        end
        c          = ch;
        r.status   = ST_IGNORED;
        since_edge = now - last_edge[c];
        if (since_edge >= {16'd0, lim.edge_lockout})
        begin
            last_edge[c] = now;
            if (lvl)
            begin
                rise_at[c] = now;
                r.status   = ST_RISE;
            end
            else
            begin
                width = now - rise_at[c];
                if (width < {16'd0, lim.min_pulse} || width > {16'd0, lim.max_pulse})
                    r.status = ST_RANGE;
                else
                    r.status = filter_step(c, width[PULSE_W-1:0], now);
            end
        end
        r.pulse = held_w[c];
        r.stamp = taken_at[c];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: checks result transfers and predicts for event transfers.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        pulse_report_t want;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                if (res.status <= ST_HELD)
                    status_seen[res.status]++;
                if (awaited_reports.size() == 0)
                begin
                    report_mismatch($sformatf("result on channel %0d with nothing awaited",
                                              res.chan_out));
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (res.chan_out !== want.chan)
                        report_mismatch($sformatf("chan_out %0d, expected %0d",
                                                  res.chan_out, want.chan));
                    if (res.status !== want.status)
                        report_mismatch($sformatf("ch %0d status %0d, expected %0d",
                                                  want.chan, res.status, want.status));
                    if (res.pulse_us !== want.pulse)
                        report_mismatch($sformatf("ch %0d pulse_us %0d, expected %0d",
                                                  want.chan, res.pulse_us, want.pulse));
                    if (res.valid_time_us !== want.stamp)
                        report_mismatch($sformatf("ch %0d valid_time_us %0h, expected %0h",
                                                  want.chan, res.valid_time_us, want.stamp));
                end
            end
            if (evt.valid && evt.ready)
            begin
                awaited_reports.push_back(evaluate_edge(evt.chan, evt.level, evt.time_us));
                events_taken++;
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_MIN_PULSE:    lim.min_pulse    = cfg.data;
                    REG_MAX_PULSE:    lim.max_pulse    = cfg.data;
                    REG_EDGE_LOCKOUT: lim.edge_lockout = cfg.data;
                    REG_SMALL_STEP:   lim.small_step   = cfg.data;
                    REG_MEDIUM_STEP:  lim.medium_step  = cfg.data;
                    REG_MEDIUM_MATCH: lim.medium_match = cfg.data;
                    REG_LARGE_MATCH:  lim.large_match  = cfg.data;
                    default:          ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: phases of full rate, a fixed pattern, random stalls and
    // occasional long stalls.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        static int rx_mode     = 0;
        static int rx_left     = 0;
        static int rx_tick     = 0;
        static int stall_left  = 0;
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end
        else
        begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            0: res.ready <= 1'b1;
            1: res.ready <= (rx_tick % 3) != 0;
            2: res.ready <= $urandom_range(0, 9) >= 3;
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    res.ready <= 1'b0;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    stall_left = $urandom_range(4, 20);
                    res.ready <= 1'b0;
                end
                else
                begin
                    res.ready <= 1'b1;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------------

    // Sends one edge event; bursts of random length are separated by gaps.
    task automatic send_event(input logic [CHAN_W-1:0] ch, input logic lvl,
                              input logic [TIME_W-1:0] t);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                evt.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        @(negedge clk);
        evt.valid   <= 1'b1;
        evt.chan    <= ch;
        evt.level   <= lvl;
        evt.time_us <= t;
        do
            @(posedge clk);
        while (!evt.ready);
        burst_left--;
    endtask

    // One pulse: a rising edge and the falling edge a width later.
    task automatic send_pulse(input int ch, input logic [TIME_W-1:0] t_rise,
                              input logic [TIME_W-1:0] width);
        send_event(CHAN_W'(ch), 1'b1, t_rise);
        send_event(CHAN_W'(ch), 1'b0, t_rise + width);
    endtask

    // Lowers valid and waits until every awaited result has come back.
    task automatic wait_results_drained();
        @(negedge clk);
        evt.valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Loads a whole register setting once the block has gone idle.
    task automatic load_limits(input logic [15:0] min_w, input logic [15:0] max_w,
                               input logic [15:0] lockout, input logic [15:0] small_s,
                               input logic [15:0] medium_s, input logic [15:0] medium_m,
                               input logic [15:0] large_m);
        wait_results_drained();
        write_reg(REG_MIN_PULSE,    min_w);
        write_reg(REG_MAX_PULSE,    max_w);
        write_reg(REG_EDGE_LOCKOUT, lockout);
        write_reg(REG_SMALL_STEP,   small_s);
        write_reg(REG_MEDIUM_STEP,  medium_s);
        write_reg(REG_MEDIUM_MATCH, medium_m);
        write_reg(REG_LARGE_MATCH,  large_m);
        settings_used++;
    endtask

    // Picks a pulse width that lands in each branch of the step filter, with
    // some out-of-range and wild widths mixed in.
    function automatic logic [TIME_W-1:0] pick_width(input int c);
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] d;
        int                lo;
        int                hi;
        int                pick;
        base = {16'd0, held_w[c]};
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            d = $urandom_range(0, lim.small_step);
        end
        else if (pick < 50)
        begin
            lo = int'(lim.small_step) + 1;
            hi = int'(lim.medium_step);
            if (hi < lo)
                hi = lo;
            d = $urandom_range(lo, hi);
        end
        else if (pick < 75)
        begin
            // Repeat the last width closely, so large steps can confirm.
            base = last_width[c];
            d    = $urandom_range(0, (lim.large_match > 0) ? lim.large_match - 1 : 0);
        end
        else if (pick < 90)
        begin
            if (lim.min_pulse <= lim.max_pulse)
                return $urandom_range(lim.min_pulse, lim.max_pulse);
            return $urandom_range(0, 65535);
        end
        else if (pick < 97)
        begin
            if (lim.min_pulse > 0 && $urandom_range(0, 1))
                return $urandom_range(0, lim.min_pulse - 1);
            return {16'd0, lim.max_pulse} + $urandom_range(1, 500);
        end
        else
        begin
            return $urandom;
        end
        return $urandom_range(0, 1) ? base + d : base - d;
    endfunction

    // Random traffic: mostly well-formed pulses, plus lone edges, edges
    // inside the lockout and events with random channel and time.
    task automatic drive_random_traffic(input int n_items, input int pause_at);
        int                sent;
        int                c;
        int                pick;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] w;
        sent = 0;
        while (sent < n_items)
        begin
            if (pause_at >= 0 && sent >= pause_at && sent < pause_at + 2)
                wait_results_drained();
            pick = $urandom_range(0, 99);
            c    = $urandom_range(0, NUM_CH - 1);
            if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(0, lim.edge_lockout);
            else
                gap = {16'd0, lim.edge_lockout} + $urandom_range(0, 2000);
            if (pick < 12)
            begin
                send_event(CHAN_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                           $urandom);
                sent++;
            end
            else if (pick < 18)
            begin
                chan_clock[c] = chan_clock[c] + gap;
                send_event(CHAN_W'(c), 1'($urandom_range(0, 1)), chan_clock[c]);
                sent++;
            end
            else
            begin
                w = pick_width(c);
                send_pulse(c, chan_clock[c] + gap, w);
                chan_clock[c] = chan_clock[c] + gap + w;
                last_width[c] = w;
                sent += 2;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Corner cases under the reset register values.
    task automatic test_directed_edges();
        // Edge earlier than the lockout after reset, then a rise at the limit.
        send_event(3'd0, 1'b1, 32'd40);
        send_event(3'd4, 1'b1, 32'd100);
        send_event(3'd5, 1'b1, 32'd0);
        // Large step: taken on the third of three consistent frames.
        send_event(3'd0, 1'b1, 32'd1000);
        send_event(3'd0, 1'b0, 32'd2500);
        send_pulse(0, 32'd20000, 32'd1510);
        send_pulse(0, 32'd40000, 32'd1505);
        // Small step, then a medium step and its confirming frame.
        send_pulse(0, 32'd60000, 32'd1540);
        send_pulse(0, 32'd80000, 32'd1700);
        send_pulse(0, 32'd100000, 32'd1690);
        // Medium step with no pending candidate: held as the new candidate.
        send_pulse(0, 32'd140000, 32'd1550);
        // Too short, too long, and too long only above sixteen bits.
        send_pulse(0, 32'd160000, 32'd500);
        send_event(3'd0, 1'b0, 32'd183000);
        send_pulse(0, 32'd200000, 32'h0001_05DC);
        // Edges inside the lockout are ignored.
        send_event(3'd0, 1'b1, 32'd300000);
        send_event(3'd0, 1'b1, 32'd300050);
        send_event(3'd0, 1'b0, 32'd300099);
        // Fall with no rise since reset, and pulses across the timestamp wrap.
        send_event(3'd1, 1'b0, 32'd1500);
        send_pulse(2, 32'hFFFF_FE00, 32'd1536);
        send_pulse(3, 32'hFFFF_FFFF, 32'd1500);
        // Channels past the last one.
        send_event(3'd6, 1'b1, 32'hFFFF_FFFF);
        send_event(3'd7, 1'b0, 32'h0000_0000);
    endtask

    task automatic test_default_traffic();
        for (int c = 0; c < NUM_CH; c++)
        begin
            chan_clock[c] = (c % 2) ? 32'hFFF0_0000 + $urandom_range(0, 65535) : $urandom;
            last_width[c] = 32'd1500;
        end
        // Part way through, the sender holds off until the results catch up.
        drive_random_traffic(400, 200);
    endtask

    task automatic test_config_zero();
        load_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drive_random_traffic(80, -1);
    endtask

    task automatic test_config_full_scale();
        load_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drive_random_traffic(80, -1);
    endtask

    task automatic test_config_inverted_limits();
        load_limits(16'd2000, 16'd1000, 16'd50, 16'd60, 16'd200, 16'd80, 16'd100);
        drive_random_traffic(60, -1);
    endtask

    task automatic test_config_wide_window();
        load_limits(16'd0, 16'hFFFF, 16'd0, 16'd10, 16'd500, 16'd30, 16'd40);
        drive_random_traffic(200, -1);
    endtask

    task automatic test_config_random();
        logic [15:0] min_w;
        logic [15:0] small_s;
        for (int k = 0; k < 2; k++)
        begin
            min_w   = 16'($urandom_range(0, 1500));
            small_s = 16'($urandom_range(0, 100));
            load_limits(min_w, 16'(min_w + $urandom_range(0, 3000)),
                        16'($urandom_range(0, 400)),
                        small_s, 16'(small_s + $urandom_range(0, 400)),
                        16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)));
            drive_random_traffic(100, -1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence of tests and final verdict.
    // ------------------------------------------------------------------------
    initial
    begin
        mismatches    = 0;
        events_taken  = 0;
        settings_used = 1;
        burst_left    = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        clear_predictor();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_edges();
        test_default_traffic();
        test_config_zero();
        test_config_full_scale();
        test_config_inverted_limits();
        test_config_wide_window();
        test_config_random();

        wait_results_drained();
        repeat (10) @(posedge clk);
        if (awaited_reports.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_reports.size()));

        $display("Coverage: %0d edge events under %0d register settings, %0d mismatches.",
                 events_taken, settings_used, mismatches);
        $display("Statuses seen: ignored %0d, rise %0d, out of range %0d, accepted %0d, held %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (mismatches == 0)
            $display("** rc_pulse_capture_validator: PASSED **");
        else
            $display("** rc_pulse_capture_validator: FAILED **");
        $finish;
    end

    // Watchdog on the whole run.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Run stopped by the watchdog after %0d cycles.", CYCLE_LIMIT);
        $display("** rc_pulse_capture_validator: FAILED **");
        $finish;
    end

endmodule
